### hw/rtl/cdes_pkg.sv
// Constants and the month table for the calendar date to epoch seconds converter.
// No dependencies.
`timescale 1ns / 1ps

package cdes_pkg;

    localparam int unsigned IN_W   = 48;
    localparam int unsigned OUT_W  = 32;

    localparam logic [15:0] EPOCH_YEAR    = 16'd1970;
    // leap years in 1..1969
    localparam logic [31:0] LEAPS_PRE     = 32'd477;
    localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
    localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [16:0] SECS_PER_MIN  = 17'd60;
    localparam logic [24:0] DAYS_PER_YEAR = 25'd365;
    // ceil(2^17 / 25); exact quotient for 14-bit dividends
    localparam logic [26:0] RECIP_25      = 27'd5243;
    localparam int unsigned RECIP_SHIFT   = 17;

    // days before the first of the (clamped) month
    function automatic logic [8:0] cum_days(input logic [3:0] month);
        logic [8:0] d;
        unique case (month)
            4'd0, 4'd1: d = 9'd0;
            4'd2:       d = 9'd31;
            4'd3:       d = 9'd59;
            4'd4:       d = 9'd90;
            4'd5:       d = 9'd120;
            4'd6:       d = 9'd151;
            4'd7:       d = 9'd181;
            4'd8:       d = 9'd212;
            4'd9:       d = 9'd243;
            4'd10:      d = 9'd273;
            4'd11:      d = 9'd304;
            default:    d = 9'd334;
        endcase
        return d;
    endfunction

endpackage

### hw/rtl/calendar_date_to_epoch_seconds_top.sv
// Calendar date to epoch seconds converter, five-stage pipeline.
// Depends on cdes_pkg.
`timescale 1ns / 1ps

// Usage:
//   The slave channel takes one date per item; the master channel returns
//   the matching seconds since 1970-01-01 00:00:00, modulo 2^32, in order.
//   Years before 1970 return zero.
//   An accepted item passes through stages 1 to 5 in order; one item is
//   accepted every cycle while the receiver keeps up.
//   Stage 1 forms the reciprocal products for the /100 and /400 terms,
//   stage 2 the leap count and leap flag, stage 3 the day sum, stage 4 the
//   day-to-seconds product, stage 5 adds the time of day into the output
//   register.
//   A stall on the master side holds the output register; upstream stages
//   keep advancing into empty slots, and s_axis_tready drops only once
//   every stage holds an item. No item is lost or repeated.
//   Reset (i_rst_n low, synchronous) empties the pipeline; payload is not
//   cleared.
module calendar_date_to_epoch_seconds_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // year[15:0], month[19:16], day[24:20], hour[29:25], minute[35:30],
    // second[41:36], zero[47:42]
    input  logic [cdes_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // epoch_seconds[31:0]
    output logic [cdes_pkg::OUT_W-1:0] m_axis_tdata
);
    import cdes_pkg::*;

    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [15:0] year_m1;

    logic en1, en2, en3, en4, en5;

    // stage 1
    logic        r_v1;
    logic [26:0] r_s1_pn;
    logic [26:0] r_s1_py;
    logic [13:0] r_s1_m4n;
    logic [13:0] r_s1_m4y;
    logic        r_s1_ylo;
    logic [15:0] r_s1_yoff;
    logic        r_s1_pre;
    logic [8:0]  r_s1_cum;
    logic        r_s1_late;
    logic [4:0]  r_s1_day;
    logic [16:0] r_s1_tod;

    // stage 2
    logic [9:0]  qn;
    logic [9:0]  qy;
    logic [13:0] qy25;
    logic        y100;
    logic        leap;
    logic        r_v2;
    logic [13:0] r_s2_leaps;
    logic        r_s2_leapadd;
    logic [24:0] r_s2_d365;
    logic        r_s2_pre;
    logic [8:0]  r_s2_cum;
    logic [4:0]  r_s2_day;
    logic [16:0] r_s2_tod;

    // stage 3
    logic        r_v3;
    logic [31:0] r_s3_days;
    logic        r_s3_pre;
    logic [16:0] r_s3_tod;

    // stage 4
    logic        r_v4;
    logic [31:0] r_s4_dsec;
    logic        r_s4_pre;
    logic [16:0] r_s4_tod;

    // stage 5 (output)
    logic        r_v5;
    logic [31:0] r_s5_secs;

    assign year    = s_axis_tdata[15:0];
    assign month   = s_axis_tdata[19:16];
    assign day     = s_axis_tdata[24:20];
    assign hour    = s_axis_tdata[29:25];
    assign minute  = s_axis_tdata[35:30];
    assign second  = s_axis_tdata[41:36];
    assign year_m1 = year - 16'd1;

    assign en5 = !r_v5 || m_axis_tready;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign s_axis_tready = en1;
    assign m_axis_tvalid = r_v5;
    assign m_axis_tdata  = r_s5_secs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en1) r_v1 <= s_axis_tvalid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
        end
    end

    // stage 1: reciprocal products, month lookup, time of day
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_pn   <= 27'(year_m1[15:2]) * RECIP_25;
            r_s1_py   <= 27'(year[15:2]) * RECIP_25;
            r_s1_m4n  <= year_m1[15:2];
            r_s1_m4y  <= year[15:2];
            r_s1_ylo  <= (year[1:0] == 2'd0);
            r_s1_yoff <= year - EPOCH_YEAR;
            r_s1_pre  <= (year < EPOCH_YEAR);
            r_s1_cum  <= cum_days(month);
            r_s1_late <= (month > 4'd2);
            r_s1_day  <= day;
            r_s1_tod  <= 17'(hour) * SECS_PER_HOUR + 17'(minute) * SECS_PER_MIN
                         + 17'(second);
        end
    end

    // stage 2: leap count through year - 1, leap flag of year, whole-year days
    assign qn   = r_s1_pn[RECIP_SHIFT+9:RECIP_SHIFT];
    assign qy   = r_s1_py[RECIP_SHIFT+9:RECIP_SHIFT];
    assign qy25 = 14'(qy) * 14'd25;
    assign y100 = r_s1_ylo && (r_s1_m4y == qy25);
    assign leap = (r_s1_ylo && !y100) || (y100 && (qy[1:0] == 2'd0));

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_leaps   <= r_s1_m4n - 14'(qn) + 14'(qn[9:2]);
            r_s2_leapadd <= leap && r_s1_late;
            r_s2_d365    <= 25'(r_s1_yoff) * DAYS_PER_YEAR;
            r_s2_pre     <= r_s1_pre;
            r_s2_cum     <= r_s1_cum;
            r_s2_day     <= r_s1_day;
            r_s2_tod     <= r_s1_tod;
        end
    end

    // stage 3: day count
    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3_days <= 32'(r_s2_d365) + 32'(r_s2_leaps) - LEAPS_PRE
                         + 32'(r_s2_cum) + 32'(r_s2_leapadd)
                         + 32'(r_s2_day) - 32'd1;
            r_s3_pre  <= r_s2_pre;
            r_s3_tod  <= r_s2_tod;
        end
    end

    // stage 4: scale days to seconds
    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_s4_dsec <= r_s3_days * SECS_PER_DAY;
            r_s4_pre  <= r_s3_pre;
            r_s4_tod  <= r_s3_tod;
        end
    end

    // stage 5: add time of day, zero before epoch
    always_ff @(posedge i_clk) begin
        if (en5) begin
            r_s5_secs <= r_s4_pre ? 32'd0 : r_s4_dsec + 32'(r_s4_tod);
        end
    end

endmodule
